FILE: src/sfe_pkg.sv
// Shared constants, command codes and controller/datapath types of the sprite frame buffer.
package sfe_pkg;

    // Screen sizes in pixels for the two resolutions
    localparam int LO_WIDTH  = 64;
    localparam int LO_HEIGHT = 32;
    localparam int HI_WIDTH  = 128;
    localparam int HI_HEIGHT = 64;

    localparam int LO_AREA  = LO_WIDTH * LO_HEIGHT;
    localparam int HI_AREA  = HI_WIDTH * HI_HEIGHT;
    localparam int FB_DEPTH = (HI_AREA > LO_AREA) ? HI_AREA : LO_AREA;
    localparam int ADDR_W   = $clog2(FB_DEPTH);

    // Coordinates: 8-bit position plus 4-bit row offset, and sizes up to 256
    localparam int VAL_W  = 9;
    localparam int PROD_W = 2 * VAL_W;

    localparam int SCROLL_STEP = 4;

    localparam logic [VAL_W-1:0]  LO_W_V  = VAL_W'(LO_WIDTH);
    localparam logic [VAL_W-1:0]  LO_H_V  = VAL_W'(LO_HEIGHT);
    localparam logic [VAL_W-1:0]  HI_W_V  = VAL_W'(HI_WIDTH);
    localparam logic [VAL_W-1:0]  HI_H_V  = VAL_W'(HI_HEIGHT);
    localparam logic [ADDR_W-1:0] LO_LAST = ADDR_W'(LO_AREA - 1);
    localparam logic [ADDR_W-1:0] HI_LAST = ADDR_W'(HI_AREA - 1);
    localparam logic [ADDR_W-1:0] FB_LAST = ADDR_W'(FB_DEPTH - 1);

    // Sprite row widths and the last bit index of each
    localparam logic [3:0] LAST_BIT_WIDE   = 4'd15;
    localparam logic [3:0] LAST_BIT_NARROW = 4'd7;
    localparam logic [4:0] ROWS_WIDE       = 5'd16;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_CLIP_EDGES = '0;

    // Command modes
    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_DRAW   = 3'd1;
    localparam logic [2:0] MODE_DOWN   = 3'd2;
    localparam logic [2:0] MODE_RIGHT  = 3'd3;
    localparam logic [2:0] MODE_LEFT   = 3'd4;
    localparam logic [2:0] MODE_LORES  = 3'd5;
    localparam logic [2:0] MODE_HIRES  = 3'd6;
    localparam logic [2:0] MODE_READ   = 3'd7;

    // Kinds of memory write-back stage operations
    localparam logic [1:0] WB_COPY = 2'd0;
    localparam logic [1:0] WB_DRAW = 2'd1;
    localparam logic [1:0] WB_READ = 2'd2;

    // Controller to datapath commands, one step each
    typedef struct packed {
        logic load;
        logic reduce;
        logic rowadd;
        logic mul;
        logic draw;
        logic walk;
        logic init;
        logic rdpx;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic red_done;
        logic draw_last;
        logic walk_last;
    } t_dp_stat;

endpackage

FILE: src/sprite_framebuffer_engine.sv
// Top level of the sprite frame buffer: configuration port, result register and checks.
//
//   channel   direction  handshake                  carries
//   command   in         i_in_valid / o_in_ready    mode, position, sprite row
//   result    out        o_out_valid / i_out_ready  collision, pixel, high_res
//   config    in         psel/penable/pwrite/pready clip_edges at byte address 0
//
// A draw row runs a coordinate reduction, the row add, a second reduction, the base
// multiply and one step per sprite pixel; clear and side scrolls walk every screen
// pixel, scroll down does so after a base multiply, a pixel read reads one cell after
// it, and a resolution set goes straight to the result. The pixel memory has one read
// and one write port. After reset a clearing pass over all FB_DEPTH (8192) cells runs first.
// A waiting result holds the controller, so the next command waits for its load.
module sprite_framebuffer_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_mode,
    input  logic [7:0]                       i_x_pos,
    input  logic [7:0]                       i_y_pos,
    input  logic [3:0]                       i_sprite_height,
    input  logic [3:0]                       i_row_offset,
    input  logic [15:0]                      i_row_bits,
    input  logic                             i_first_row,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_collision,
    output logic                             o_pixel,
    output logic                             o_high_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sfe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sfe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic              r_clip;
    logic              r_out_valid, r_out_collision, r_out_pixel, r_out_high_res;
    logic              w_out_free, w_out_load;
    logic              w_dp_collision, w_dp_pixel, w_dp_high_res;
    logic [sfe_pkg::APB_ADDR_W-3:0] w_reg_idx;
    sfe_pkg::t_dp_cmd  w_cmd;
    sfe_pkg::t_dp_stat w_stat;

    // Configuration register
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[sfe_pkg::APB_ADDR_W-1:2];
    assign prdata    = (w_reg_idx == sfe_pkg::REG_CLIP_EDGES) ?
                       {{(sfe_pkg::APB_DATA_W-1){1'b0}}, r_clip} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     (w_reg_idx == sfe_pkg::REG_CLIP_EDGES)) begin
            r_clip <= pwdata[0];
        end
    end

    sfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    sfe_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_clip          (r_clip),
        .i_mode          (i_mode),
        .i_x_pos         (i_x_pos),
        .i_y_pos         (i_y_pos),
        .i_sprite_height (i_sprite_height),
        .i_row_offset    (i_row_offset),
        .i_row_bits      (i_row_bits),
        .i_first_row     (i_first_row),
        .o_stat          (w_stat),
        .o_collision     (w_dp_collision),
        .o_pixel         (w_dp_pixel),
        .o_high_res      (w_dp_high_res)
    );

    // Result register: load when free, drop valid once the transaction completes
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_collision <= w_dp_collision;
            r_out_pixel     <= w_dp_pixel;
            r_out_high_res  <= w_dp_high_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_collision = r_out_collision;
    assign o_pixel     = r_out_pixel;
    assign o_high_res  = r_out_high_res;

    // Reset always starts the clearing pass, so no command is taken right after it
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("command accepted during reset clearing pass");

    // Every accepted command leaves idle, so commands are never accepted back to back
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second command accepted back to back");

    // A high-res command takes effect in the next cycle
    a_hires_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_mode == sfe_pkg::MODE_HIRES)) |=> w_dp_high_res)
        else $error("high resolution not set after command");

    // A result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_out_load)
        else $error("pending result overwritten");

endmodule

FILE: src/sfe_ctrl.sv
// Command sequencer of the sprite frame buffer: steps the datapath through each command.
module sfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_mode,
    input  logic              i_out_free,
    input  sfe_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_load,
    output sfe_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_ROWADD = 4'd3;
    localparam logic [3:0] S_MOD2   = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_DRAW   = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_RDPX   = 4'd8;
    localparam logic [3:0] S_DRAIN  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] r_state, n_state;
    logic [2:0] r_mode, n_mode;

    // Next state and per-cycle commands
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        o_cmd      = '0;
        o_out_load = 1'b0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_INIT: begin
                o_cmd.walk = 1'b1;
                o_cmd.init = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_mode;
                    case (i_mode)
                        sfe_pkg::MODE_CLEAR,
                        sfe_pkg::MODE_RIGHT,
                        sfe_pkg::MODE_LEFT:  n_state = S_WALK;
                        sfe_pkg::MODE_DRAW:  n_state = S_MOD;
                        sfe_pkg::MODE_DOWN,
                        sfe_pkg::MODE_READ:  n_state = S_MUL;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.reduce = 1'b1;
                if (i_stat.red_done) begin
                    n_state = S_ROWADD;
                end
            end
            S_ROWADD: begin
                o_cmd.rowadd = 1'b1;
                n_state      = S_MOD2;
            end
            S_MOD2: begin
                o_cmd.reduce = 1'b1;
                if (i_stat.red_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                case (r_mode)
                    sfe_pkg::MODE_DRAW: n_state = S_DRAW;
                    sfe_pkg::MODE_DOWN: n_state = S_WALK;
                    default:            n_state = S_RDPX;
                endcase
            end
            S_DRAW: begin
                o_cmd.draw = 1'b1;
                if (i_stat.draw_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_RDPX: begin
                o_cmd.rdpx = 1'b1;
                n_state    = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mode  <= sfe_pkg::MODE_CLEAR;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule

FILE: src/sfe_datapath.sv
// Datapath of the sprite frame buffer: pixel memory, address walker and draw/scroll logic.
module sfe_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfe_pkg::t_dp_cmd  i_cmd,
    input  logic              i_clip,
    input  logic [2:0]        i_mode,
    input  logic [7:0]        i_x_pos,
    input  logic [7:0]        i_y_pos,
    input  logic [3:0]        i_sprite_height,
    input  logic [3:0]        i_row_offset,
    input  logic [15:0]       i_row_bits,
    input  logic              i_first_row,
    output sfe_pkg::t_dp_stat o_stat,
    output logic              o_collision,
    output logic              o_pixel,
    output logic              o_high_res
);

    localparam int VW = sfe_pkg::VAL_W;
    localparam int AW = sfe_pkg::ADDR_W;
    localparam int PW = sfe_pkg::PROD_W;

    // Pixel memory, one bit per cell
    logic          mem [sfe_pkg::FB_DEPTH];
    logic          r_q;
    logic          r_fwd, r_fwd_d;

    // Command state
    logic          r_hires, r_collision, r_pix;
    logic [2:0]    r_mode;
    logic [VW-1:0] r_vx, r_vy, r_px, r_col;
    logic [3:0]    r_off, r_height, r_i;
    logic [15:0]   r_bits;
    logic          r_inrange, r_yover, r_wrap;
    logic [PW-1:0] r_base;
    logic [AW-1:0] r_addr;

    // Write-back stage
    logic          r_wr_pend, r_src_ok;
    logic [1:0]    r_wr_kind;
    logic [AW-1:0] r_wr_addr;

    logic [VW-1:0] w_cur_w, w_cur_h, w_sum, w_col_next;
    logic [AW-1:0] w_cur_last, w_walk_limit, w_walk_src, w_draw_addr, w_raddr, w_addr_next;
    logic [PW-1:0] w_addr_ext;
    logic [4:0]    w_rows;
    logic [7:0]    w_narrow;
    logic          w_wide, w_row_skip, w_bit, w_draw_ok;
    logic          w_walk_desc, w_walk_clear, w_src_ok, w_ld_desc;
    logic          w_rd, w_we, w_wdata;

    // Current resolution
    assign w_cur_w    = r_hires ? sfe_pkg::HI_W_V : sfe_pkg::LO_W_V;
    assign w_cur_h    = r_hires ? sfe_pkg::HI_H_V : sfe_pkg::LO_H_V;
    assign w_cur_last = r_hires ? sfe_pkg::HI_LAST : sfe_pkg::LO_LAST;

    // Sprite row shape and per-pixel enable
    assign w_wide      = r_hires && (r_height == 4'd0);
    assign w_rows      = w_wide ? sfe_pkg::ROWS_WIDE : {1'b0, r_height};
    assign w_row_skip  = ({1'b0, r_off} >= w_rows) || (i_clip && r_yover);
    assign w_narrow    = r_bits[7:0];
    assign w_bit       = w_wide ? r_bits[sfe_pkg::LAST_BIT_WIDE - r_i]
                                : w_narrow[3'd7 - r_i[2:0]];
    assign w_draw_ok   = w_bit && !(i_clip && r_wrap) && !w_row_skip;
    assign w_draw_addr = AW'(r_base + PW'(r_px));
    assign w_sum       = r_vy + VW'(r_off);

    // Walker direction, end and source address
    assign w_walk_desc  = !i_cmd.init && ((r_mode == sfe_pkg::MODE_DOWN) ||
                                         (r_mode == sfe_pkg::MODE_RIGHT));
    assign w_walk_clear = i_cmd.init || (r_mode == sfe_pkg::MODE_CLEAR);
    assign w_walk_limit = i_cmd.init ? sfe_pkg::FB_LAST : w_cur_last;
    assign w_addr_ext   = PW'(r_addr);

    always_comb begin
        w_src_ok   = 1'b0;
        w_walk_src = r_addr;
        case (r_mode)
            sfe_pkg::MODE_DOWN: begin
                w_src_ok   = w_addr_ext >= r_base;
                w_walk_src = AW'(w_addr_ext - r_base);
            end
            sfe_pkg::MODE_RIGHT: begin
                w_src_ok   = r_col >= VW'(sfe_pkg::SCROLL_STEP);
                w_walk_src = r_addr - AW'(sfe_pkg::SCROLL_STEP);
            end
            sfe_pkg::MODE_LEFT: begin
                w_src_ok   = (r_col + VW'(sfe_pkg::SCROLL_STEP)) < w_cur_w;
                w_walk_src = r_addr + AW'(sfe_pkg::SCROLL_STEP);
            end
            default: begin
                w_src_ok = 1'b0;
            end
        endcase
        if (w_walk_clear) begin
            w_src_ok = 1'b0;
        end
    end

    always_comb begin
        if (w_walk_desc) begin
            w_addr_next = r_addr - AW'(1);
            w_col_next  = (r_col == '0) ? w_cur_w - VW'(1) : r_col - VW'(1);
        end else begin
            w_addr_next = r_addr + AW'(1);
            w_col_next  = (r_col + VW'(1) == w_cur_w) ? '0 : r_col + VW'(1);
        end
    end

    // Memory read address
    always_comb begin
        if (i_cmd.draw) begin
            w_raddr = w_draw_addr;
        end else if (i_cmd.walk) begin
            w_raddr = w_walk_src;
        end else if (i_cmd.rdpx) begin
            w_raddr = AW'(r_base + PW'(r_vx));
        end else begin
            w_raddr = r_addr;
        end
    end

    // Read data with bypass of a same-cycle write; write-back value
    assign w_rd    = r_fwd ? r_fwd_d : r_q;
    assign w_we    = r_wr_pend && (r_wr_kind != sfe_pkg::WB_READ);
    assign w_wdata = (r_wr_kind == sfe_pkg::WB_DRAW) ? !w_rd : (r_src_ok && w_rd);

    assign w_ld_desc = (i_mode == sfe_pkg::MODE_DOWN) || (i_mode == sfe_pkg::MODE_RIGHT);

    // Memory port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_wr_addr] <= w_wdata;
        end
        r_q     <= mem[w_raddr];
        r_fwd   <= w_we && (r_wr_addr == w_raddr);
        r_fwd_d <= w_wdata;
    end

    // Control registers: resolution, collision flag, write-back valid, walker position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hires     <= 1'b0;
            r_collision <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_addr      <= '0;
            r_col       <= '0;
        end else begin
            r_wr_pend <= (i_cmd.draw && w_draw_ok) || i_cmd.walk || i_cmd.rdpx;
            if (i_cmd.load) begin
                if (i_mode == sfe_pkg::MODE_LORES) begin
                    r_hires <= 1'b0;
                end
                if (i_mode == sfe_pkg::MODE_HIRES) begin
                    r_hires <= 1'b1;
                end
                if ((i_mode == sfe_pkg::MODE_DRAW) && i_first_row) begin
                    r_collision <= 1'b0;
                end
                r_addr <= w_ld_desc ? w_cur_last : '0;
                r_col  <= w_ld_desc ? w_cur_w - VW'(1) : '0;
            end else if (i_cmd.walk) begin
                r_addr <= w_addr_next;
                r_col  <= w_col_next;
            end
            // Flag a lit pixel that a draw turns off
            if (r_wr_pend && (r_wr_kind == sfe_pkg::WB_DRAW) && w_rd) begin
                r_collision <= 1'b1;
            end
        end
    end

    // Command payload and arithmetic steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_vx      <= VW'(i_x_pos);
            r_vy      <= (i_mode == sfe_pkg::MODE_DOWN) ? VW'(i_sprite_height) : VW'(i_y_pos);
            r_off     <= i_row_offset;
            r_height  <= i_sprite_height;
            r_bits    <= i_row_bits;
            r_inrange <= (VW'(i_x_pos) < w_cur_w) && (VW'(i_y_pos) < w_cur_h);
            r_pix     <= 1'b0;
        end
        // Subtract the screen size until both coordinates are on screen
        if (i_cmd.reduce) begin
            if (r_vx >= w_cur_w) begin
                r_vx <= r_vx - w_cur_w;
            end
            if (r_vy >= w_cur_h) begin
                r_vy <= r_vy - w_cur_h;
            end
        end
        if (i_cmd.rowadd) begin
            r_vy    <= w_sum;
            r_yover <= w_sum >= w_cur_h;
            r_px    <= r_vx;
            r_wrap  <= 1'b0;
            r_i     <= 4'd0;
        end
        if (i_cmd.mul) begin
            r_base <= r_vy * w_cur_w;
        end
        // Advance the column, wrapping at the right edge
        if (i_cmd.draw) begin
            r_i <= r_i + 4'd1;
            if (r_px + VW'(1) == w_cur_w) begin
                r_px   <= '0;
                r_wrap <= 1'b1;
            end else begin
                r_px <= r_px + VW'(1);
            end
        end
        // Hand the operation to the write-back stage
        if (i_cmd.draw) begin
            r_wr_kind <= sfe_pkg::WB_DRAW;
            r_wr_addr <= w_draw_addr;
            r_src_ok  <= 1'b0;
        end else if (i_cmd.rdpx) begin
            r_wr_kind <= sfe_pkg::WB_READ;
            r_wr_addr <= w_raddr;
            r_src_ok  <= r_inrange;
        end else begin
            r_wr_kind <= sfe_pkg::WB_COPY;
            r_wr_addr <= r_addr;
            r_src_ok  <= w_src_ok;
        end
        if (r_wr_pend && (r_wr_kind == sfe_pkg::WB_READ)) begin
            r_pix <= r_src_ok && w_rd;
        end
    end

    assign o_stat.red_done  = (r_vx < w_cur_w) && (r_vy < w_cur_h);
    assign o_stat.draw_last = r_i == (w_wide ? sfe_pkg::LAST_BIT_WIDE : sfe_pkg::LAST_BIT_NARROW);
    assign o_stat.walk_last = w_walk_desc ? (r_addr == '0) : (r_addr == w_walk_limit);

    assign o_collision = r_collision;
    assign o_pixel     = r_pix;
    assign o_high_res  = r_hires;

endmodule
